>>> design/sfcan_pkg.sv
// ----------------------------------------------------------------------------
// sfcan_pkg
// Shared constants, register indexes, checksum mode codes and CRC byte-update
// functions for the serial frame checksum unit.
// ----------------------------------------------------------------------------
`default_nettype none

package sfcan_pkg;

  localparam int RX_BUFFER_BYTES = 64;
  localparam int CNT_W           = $clog2(RX_BUFFER_BYTES);

  // configuration register indexes
  localparam logic [2:0] REG_CHECKSUM_MODE    = 3'd0;
  localparam logic [2:0] REG_ACK_ENABLE       = 3'd1;
  localparam logic [2:0] REG_ACK_VALUE        = 3'd2;
  localparam logic [2:0] REG_NAK_ENABLE       = 3'd3;
  localparam logic [2:0] REG_NAK_VALUE        = 3'd4;
  localparam logic [2:0] REG_DELIMITER_ENABLE = 3'd5;
  localparam logic [2:0] REG_DELIMITER_VALUE  = 3'd6;

  // checksum modes
  localparam logic [2:0] MODE_NONE   = 3'd0;
  localparam logic [2:0] MODE_XOR    = 3'd1;
  localparam logic [2:0] MODE_SUM    = 3'd2;
  localparam logic [2:0] MODE_CRC8   = 3'd3;
  localparam logic [2:0] MODE_CRC16  = 3'd4;
  localparam logic [2:0] MODE_HEADER = 3'd5;

  localparam logic [7:0]  HEADER_BYTE = 8'h80;
  localparam logic [15:0] CRC16_INIT  = 16'hFFFF;
  localparam logic [7:0]  CRC8_POLY   = 8'h07;
  localparam logic [15:0] CRC16_POLY  = 16'hA001;

  // crc-8, polynomial 0x07, msb first
  function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ((c << 1) ^ CRC8_POLY) : (c << 1);
    end
    return c;
  endfunction

  // modbus crc-16, reflected polynomial 0xa001
  function automatic logic [15:0] crc16_next(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC16_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

>>> design/serial_frame_checksum_ack_nak_unit.sv
// ----------------------------------------------------------------------------
// serial_frame_checksum_ack_nak_unit
// Forwards received bytes, closes frames and checks their trailing checksum,
// giving an acknowledge or negative acknowledge byte at frame close when enabled.
// ----------------------------------------------------------------------------
// One result per received byte. Each taken byte's result appears in the
// output register on the following cycle; running checksums are updated in
// the same cycle, so throughput is one byte per clock while in_stall is low.
// The only back-pressure comes from the output register: in_stall is high
// while it holds a result and out_stall is high. Configuration writes are
// always taken (cfg_ready is tied high) and should only be made while idle.
`default_nettype none

module serial_frame_checksum_ack_nak_unit
  import sfcan_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  // configuration
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [2:0] cfg_index,
  input  wire logic [7:0] cfg_data,
  // receive side
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] rx_byte,
  input  wire logic       chunk_end,
  // result side
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      fwd_byte,
  output logic            fwd_last,
  output logic            reply_valid,
  output logic [7:0]      reply_byte,
  output logic            frame_ok
);

  // configuration registers
  logic [2:0] checksum_mode;
  logic       ack_enable;
  logic [7:0] ack_value;
  logic       nak_enable;
  logic [7:0] nak_value;
  logic       delimiter_enable;
  logic [7:0] delimiter_value;

  // frame state
  logic [CNT_W-1:0] byte_count;
  logic [7:0]       prev_byte_one;
  logic [7:0]       prev_byte_two;
  logic [7:0]       run_xor;
  logic [7:0]       run_sum;
  logic [7:0]       run_crc8;
  logic [15:0]      run_crc16;
  logic [7:0]       header_sum;
  logic             header_ok;

  logic             in_take;
  logic [CNT_W:0]   count_inc;
  logic             close;
  logic             ok;
  logic [15:0]      crc16_tail;
  logic [15:0]      crc16_next_val;
  logic             reply_valid_next;
  logic [7:0]       reply_byte_next;

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid & out_stall;
  assign in_take   = in_valid & ~in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      checksum_mode    <= MODE_NONE;
      ack_enable       <= 1'b0;
      ack_value        <= 8'h00;
      nak_enable       <= 1'b0;
      nak_value        <= 8'h00;
      delimiter_enable <= 1'b0;
      delimiter_value  <= 8'h00;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_CHECKSUM_MODE:    checksum_mode    <= cfg_data[2:0];
        REG_ACK_ENABLE:       ack_enable       <= cfg_data[0];
        REG_ACK_VALUE:        ack_value        <= cfg_data;
        REG_NAK_ENABLE:       nak_enable       <= cfg_data[0];
        REG_NAK_VALUE:        nak_value        <= cfg_data;
        REG_DELIMITER_ENABLE: delimiter_enable <= cfg_data[0];
        REG_DELIMITER_VALUE:  delimiter_value  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign count_inc      = {1'b0, byte_count} + {{CNT_W{1'b0}}, 1'b1};
  assign crc16_next_val = crc16_next(run_crc16, prev_byte_two);
  assign crc16_tail     = (byte_count >= CNT_W'(2)) ? crc16_next_val : run_crc16;

  always_comb begin
    close = delimiter_enable ? (rx_byte == delimiter_value) : chunk_end;
    if (count_inc >= (CNT_W+1)'(RX_BUFFER_BYTES)) begin
      close = 1'b1;
    end
  end

  always_comb begin
    ok = 1'b0;
    if (close) begin
      case (checksum_mode)
        MODE_XOR:    ok = (run_xor == rx_byte);
        MODE_SUM:    ok = (run_sum == rx_byte);
        MODE_CRC8:   ok = (run_crc8 == rx_byte);
        MODE_CRC16:  ok = (byte_count >= CNT_W'(1)) && (prev_byte_one == crc16_tail[7:0])
                          && (rx_byte == crc16_tail[15:8]);
        MODE_HEADER: ok = (byte_count >= CNT_W'(3)) && header_ok && (header_sum == rx_byte);
        default:     ok = 1'b0;
      endcase
    end
  end

  always_comb begin
    reply_valid_next = 1'b0;
    reply_byte_next  = 8'h00;
    if (close && checksum_mode != MODE_NONE) begin
      if (ok && ack_enable) begin
        reply_valid_next = 1'b1;
        reply_byte_next  = ack_value;
      end else if (!ok && nak_enable) begin
        reply_valid_next = 1'b1;
        reply_byte_next  = nak_value;
      end
    end
  end

  // running frame state
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count    <= '0;
      prev_byte_one <= 8'h00;
      prev_byte_two <= 8'h00;
      run_xor       <= 8'h00;
      run_sum       <= 8'h00;
      run_crc8      <= 8'h00;
      run_crc16     <= CRC16_INIT;
      header_sum    <= 8'h00;
      header_ok     <= 1'b1;
    end else if (in_take) begin
      if (close) begin
        byte_count    <= '0;
        prev_byte_one <= 8'h00;
        prev_byte_two <= 8'h00;
        run_xor       <= 8'h00;
        run_sum       <= 8'h00;
        run_crc8      <= 8'h00;
        run_crc16     <= CRC16_INIT;
        header_sum    <= 8'h00;
        header_ok     <= 1'b1;
      end else begin
        byte_count    <= count_inc[CNT_W-1:0];
        prev_byte_one <= rx_byte;
        prev_byte_two <= prev_byte_one;
        run_xor       <= run_xor ^ rx_byte;
        run_sum       <= run_sum + rx_byte;
        run_crc8      <= crc8_next(run_crc8, rx_byte);
        run_crc16     <= crc16_tail;
        if (byte_count < CNT_W'(3)) begin
          if (rx_byte != HEADER_BYTE) begin
            header_ok <= 1'b0;
          end
        end else begin
          header_sum <= header_sum + rx_byte;
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      fwd_byte    <= rx_byte;
      fwd_last    <= close;
      reply_valid <= reply_valid_next;
      reply_byte  <= reply_byte_next;
      frame_ok    <= ok;
    end
  end

endmodule

`default_nettype wire
